// ===== src/wtsp_pkg.sv =====
// Shared types, constants and command bundle for the world-to-screen projector.
// Depends on nothing; every other file refers to it by scoped names.
package wtsp_pkg;

  // Default parameter values
  localparam int unsigned CoordWidthDef = 32;
  localparam int unsigned FracBitsDef   = 16;

  // Matrix store
  localparam int unsigned MatWords = 12;
  localparam int unsigned MatW     = 32;

  // Configuration register indexes and reset values
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;
  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMinDepth     = 2'd2;
  localparam int unsigned ScrW   = 14;
  localparam int unsigned DepthW = 31;
  localparam logic [ScrW-1:0]   ScreenWidthRst  = 14'd1920;
  localparam logic [ScrW-1:0]   ScreenHeightRst = 14'd1080;
  localparam logic [DepthW-1:0] MinDepthRst     = 31'd66;

  // Input kinds
  localparam logic KindLoad    = 1'b0;
  localparam logic KindProject = 1'b1;

  // Arithmetic widths
  localparam int unsigned AccW    = 64;  // dot product accumulator, wraps
  localparam int unsigned DotW    = 50;  // clamped dot product, +-2^48
  localparam int unsigned ChunkW  = 16;  // multiplier digit
  localparam int unsigned ChunkIdxW = 2;
  localparam int unsigned ScaleChunks = AccW / ChunkW;
  localparam int unsigned MulAW   = 33;
  localparam int unsigned MulBW   = ChunkW + 1;
  localparam int unsigned MulW    = MulAW + MulBW;
  localparam int unsigned NumW    = 63;  // magnitude of a numerator
  localparam int unsigned DenW    = 50;  // twice the depth
  localparam int unsigned ResW    = 16;
  localparam logic signed [AccW-1:0] DotLimit = 64'sd281474976710656;

  typedef enum logic [1:0] {
    A_MAT,
    A_WIDTH,
    A_HEIGHT
  } a_sel_e;

  typedef enum logic [2:0] {
    B_PX,
    B_PY,
    B_PZ,
    B_XC,
    B_YC
  } b_sel_e;

  typedef enum logic [2:0] {
    D_ACC_X,
    D_ACC_Y,
    D_ACC_W,
    D_NUM_X,
    D_NUM_Y
  } dest_e;

  typedef struct packed {
    logic                 mat_write;
    logic                 point_load;
    logic                 mul_en;
    a_sel_e               a_sel;
    logic [3:0]           mat_idx;
    b_sel_e               b_sel;
    logic [ChunkIdxW-1:0] chunk;
    logic                 first;
    logic                 last;
    dest_e                dest;
    logic                 clamp;
    logic                 div_start;
    logic                 res_write;
    logic                 res_zero;
  } cmd_t;

  typedef struct packed {
    logic visible;
    logic div_done;
  } status_t;

endpackage

// ===== src/wtsp_if.sv =====
// Valid/ready channel interfaces for point input and pixel output.
// Depends on wtsp_pkg for field widths.
interface wtsp_in_if #(
  parameter int unsigned COORD_WIDTH = wtsp_pkg::CoordWidthDef
);
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [3:0]                    entry_index;
  logic signed [31:0]            entry_value;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] point_z;

  modport source (output valid, kind, entry_index, entry_value, point_x, point_y, point_z,
                  input ready);
  modport sink   (input valid, kind, entry_index, entry_value, point_x, point_y, point_z,
                  output ready);
endinterface

interface wtsp_out_if;
  logic               valid;
  logic               ready;
  logic               on_screen;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;

  modport source (output valid, on_screen, screen_x, screen_y, input ready);
  modport sink   (input valid, on_screen, screen_x, screen_y, output ready);
endinterface

// ===== src/wtsp_div.sv =====
// Two-lane restoring divider sharing one denominator, one quotient bit per cycle.
// Depends on wtsp_pkg for widths.
module wtsp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wtsp_pkg::NumW-1:0]  num_a_i,
  input  logic [wtsp_pkg::NumW-1:0]  num_b_i,
  input  logic [wtsp_pkg::DenW-1:0]  den_i,
  output logic                       done_o,
  output logic [wtsp_pkg::NumW-1:0]  quo_a_o,
  output logic [wtsp_pkg::NumW-1:0]  quo_b_o,
  output logic                       rnz_a_o,
  output logic                       rnz_b_o
);
  localparam int unsigned NumW = wtsp_pkg::NumW;
  localparam int unsigned DenW = wtsp_pkg::DenW;
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DenW-1:0] rem_q [2];
  logic [NumW-1:0] quo_q [2];
  logic [NumW-1:0] num_in [2];

  assign num_in[0] = num_a_i;
  assign num_in[1] = num_b_i;

  // Step control: count quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(NumW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) den_q <= den_i;
  end

  // Shift, trial subtract, restore
  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic [DenW:0] trial;
    logic [DenW:0] diff;
    assign trial = {rem_q[l], quo_q[l][NumW-1]};
    assign diff  = trial - {1'b0, den_q};

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q[l] <= '0;
        quo_q[l] <= num_in[l];
      end else if (busy_q) begin
        if (!diff[DenW]) begin
          rem_q[l] <= diff[DenW-1:0];
          quo_q[l] <= {quo_q[l][NumW-2:0], 1'b1};
        end else begin
          rem_q[l] <= trial[DenW-1:0];
          quo_q[l] <= {quo_q[l][NumW-2:0], 1'b0};
        end
      end
    end
  end

  assign done_o  = done_q;
  assign quo_a_o = quo_q[0];
  assign quo_b_o = quo_q[1];
  assign rnz_a_o = |rem_q[0];
  assign rnz_b_o = |rem_q[1];

endmodule

// ===== src/wtsp_datapath.sv =====
// Datapath: matrix and configuration registers, digit multiplier, accumulators,
// clamp, divider and result register. Depends on wtsp_pkg and wtsp_div.
module wtsp_datapath #(
  parameter int unsigned COORD_WIDTH = wtsp_pkg::CoordWidthDef,
  parameter int unsigned FRAC_BITS   = wtsp_pkg::FracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wtsp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [wtsp_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [3:0]                         entry_index_i,
  input  logic signed [31:0]                 entry_value_i,
  input  logic signed [COORD_WIDTH-1:0]      point_x_i,
  input  logic signed [COORD_WIDTH-1:0]      point_y_i,
  input  logic signed [COORD_WIDTH-1:0]      point_z_i,
  input  wtsp_pkg::cmd_t                     cmd_i,
  output wtsp_pkg::status_t                  status_o,
  output logic                               on_screen_o,
  output logic signed [wtsp_pkg::ResW-1:0]   screen_x_o,
  output logic signed [wtsp_pkg::ResW-1:0]   screen_y_o
);
  localparam int unsigned AccW   = wtsp_pkg::AccW;
  localparam int unsigned DotW   = wtsp_pkg::DotW;
  localparam int unsigned ChunkW = wtsp_pkg::ChunkW;
  localparam int unsigned MulAW  = wtsp_pkg::MulAW;
  localparam int unsigned MulBW  = wtsp_pkg::MulBW;
  localparam int unsigned MulW   = wtsp_pkg::MulW;
  localparam int unsigned NumW   = wtsp_pkg::NumW;
  localparam int unsigned ResW   = wtsp_pkg::ResW;
  localparam int unsigned ScrW   = wtsp_pkg::ScrW;

  typedef struct packed {
    logic                           valid;
    logic                           first;
    logic                           last;
    logic [wtsp_pkg::ChunkIdxW-1:0] chunk;
    wtsp_pkg::dest_e                dest;
  } tag_t;

  logic [wtsp_pkg::MatW-1:0]   mat_q [wtsp_pkg::MatWords];
  logic [ScrW-1:0]             scr_w_q, scr_h_q;
  logic [wtsp_pkg::DepthW-1:0] min_depth_q;
  logic signed [AccW-1:0]      px_q, py_q, pz_q;
  logic signed [AccW-1:0]      acc_q [3];
  logic signed [DotW-1:0]      xc_q, yc_q, wc_q;
  logic signed [AccW-1:0]      num_x_q, num_y_q;
  logic signed [MulW-1:0]      mult_q;
  logic signed [AccW-1:0]      prod_q;
  tag_t                        t1_q, t2_q;
  logic signed [MulAW-1:0]     op_a;
  logic signed [MulBW-1:0]     op_b;
  logic signed [AccW-1:0]      b_word;
  logic [ChunkW-1:0]           b_digit;
  logic signed [AccW-1:0]      mult_ext;
  logic signed [AccW-1:0]      wc_ext;
  logic                        div_done;
  logic [NumW-1:0]             quo_x, quo_y;
  logic                        rnz_x, rnz_y;
  logic                        on_q;
  logic signed [ResW-1:0]      sx_q, sy_q;

  function automatic logic signed [AccW-1:0] clamp_dot(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] r;
    r = v;
    if (v > wtsp_pkg::DotLimit) r = wtsp_pkg::DotLimit;
    else if (v < -wtsp_pkg::DotLimit) r = -wtsp_pkg::DotLimit;
    return r;
  endfunction

  // Truncate half + floor(N/d) towards zero and saturate
  function automatic logic signed [ResW-1:0] axis_res(input logic [ScrW-1:0] size,
                                                        input logic neg,
                                                        input logic [NumW-1:0] q,
                                                        input logic rnz);
    logic signed [AccW:0] qe, fl;
    logic signed [ResW-1:0] r;
    qe = {2'b00, q};
    if (neg) qe = rnz ? ~qe : -qe;
    fl = qe + (AccW + 1)'(size >> 1);
    if (fl < 0 && rnz) fl = fl + 1;
    if (fl > (AccW + 1)'(32767)) r = 16'sh7FFF;
    else if (fl < -(AccW + 1)'(32768)) r = 16'sh8000;
    else r = fl[ResW-1:0];
    return r;
  endfunction

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scr_w_q     <= wtsp_pkg::ScreenWidthRst;
      scr_h_q     <= wtsp_pkg::ScreenHeightRst;
      min_depth_q <= wtsp_pkg::MinDepthRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wtsp_pkg::CfgScreenWidth:  scr_w_q     <= cfg_data_i[ScrW-1:0];
        wtsp_pkg::CfgScreenHeight: scr_h_q     <= cfg_data_i[ScrW-1:0];
        wtsp_pkg::CfgMinDepth:     min_depth_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Matrix words; drop loads beyond the last word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wtsp_pkg::MatWords; i++) mat_q[i] <= '0;
    end else if (cmd_i.mat_write && entry_index_i < 4'(wtsp_pkg::MatWords)) begin
      mat_q[entry_index_i] <= entry_value_i;
    end
  end

  // Operand selection for the digit multiplier
  always_comb begin
    unique case (cmd_i.a_sel)
      wtsp_pkg::A_MAT:    op_a = MulAW'($signed(mat_q[cmd_i.mat_idx]));
      wtsp_pkg::A_WIDTH:  op_a = MulAW'(scr_w_q);
      wtsp_pkg::A_HEIGHT: op_a = MulAW'(scr_h_q);
      default:            op_a = '0;
    endcase
    unique case (cmd_i.b_sel)
      wtsp_pkg::B_PX: b_word = px_q;
      wtsp_pkg::B_PY: b_word = py_q;
      wtsp_pkg::B_PZ: b_word = pz_q;
      wtsp_pkg::B_XC: b_word = AccW'(xc_q);
      wtsp_pkg::B_YC: b_word = AccW'(yc_q);
      default:        b_word = '0;
    endcase
    b_digit = b_word[cmd_i.chunk*ChunkW +: ChunkW];
    op_b    = cmd_i.last ? {b_digit[ChunkW-1], b_digit} : {1'b0, b_digit};
  end

  assign mult_ext = AccW'(mult_q) <<< (t1_q.chunk * ChunkW);
  assign wc_ext   = AccW'(wc_q);

  // Multiply stage and tag pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_q <= '0;
      t2_q <= '0;
    end else begin
      t1_q <= '{valid: cmd_i.mul_en, first: cmd_i.first, last: cmd_i.last,
                chunk: cmd_i.chunk, dest: cmd_i.dest};
      t2_q <= t1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) mult_q <= op_a * op_b;
    if (t1_q.valid) prod_q <= t1_q.first ? mult_ext : prod_q + mult_ext;
  end

  // Point latch, accumulators, clamp and numerators
  always_ff @(posedge clk_i) begin
    if (cmd_i.point_load) begin
      px_q     <= AccW'(point_x_i);
      py_q     <= AccW'(point_y_i);
      pz_q     <= AccW'(point_z_i);
      acc_q[0] <= AccW'($signed(mat_q[3]));
      acc_q[1] <= AccW'($signed(mat_q[7]));
      acc_q[2] <= AccW'($signed(mat_q[11]));
    end else if (t2_q.valid && t2_q.last) begin
      unique case (t2_q.dest)
        wtsp_pkg::D_ACC_X: acc_q[0] <= acc_q[0] + (prod_q >>> FRAC_BITS);
        wtsp_pkg::D_ACC_Y: acc_q[1] <= acc_q[1] + (prod_q >>> FRAC_BITS);
        wtsp_pkg::D_ACC_W: acc_q[2] <= acc_q[2] + (prod_q >>> FRAC_BITS);
        wtsp_pkg::D_NUM_X: num_x_q  <= prod_q + wc_ext;
        wtsp_pkg::D_NUM_Y: num_y_q  <= -prod_q - wc_ext;
        default: ;
      endcase
    end
    if (cmd_i.clamp) begin
      xc_q <= DotW'(clamp_dot(acc_q[0]));
      yc_q <= DotW'(clamp_dot(acc_q[1]));
      wc_q <= DotW'(clamp_dot(acc_q[2]));
    end
  end

  assign status_o.visible  = wc_q > $signed(DotW'(min_depth_q));
  assign status_o.div_done = div_done;

  // Divide both numerators by twice the depth
  wtsp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_a_i (num_x_q[AccW-1] ? NumW'(-num_x_q) : num_x_q[NumW-1:0]),
    .num_b_i (num_y_q[AccW-1] ? NumW'(-num_y_q) : num_y_q[NumW-1:0]),
    .den_i   ({wc_q[DotW-2:0], 1'b0}),
    .done_o  (div_done),
    .quo_a_o (quo_x),
    .quo_b_o (quo_y),
    .rnz_a_o (rnz_x),
    .rnz_b_o (rnz_y)
  );

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_write) begin
      if (cmd_i.res_zero) begin
        on_q <= 1'b0;
        sx_q <= '0;
        sy_q <= '0;
      end else begin
        on_q <= 1'b1;
        sx_q <= axis_res(scr_w_q, num_x_q[AccW-1], quo_x, rnz_x);
        sy_q <= axis_res(scr_h_q, num_y_q[AccW-1], quo_y, rnz_y);
      end
    end
  end

  assign on_screen_o = on_q;
  assign screen_x_o  = sx_q;
  assign screen_y_o  = sy_q;

endmodule

// ===== src/wtsp_ctrl.sv =====
// Controller: sequences loads, the dot product digits, clamp, scaling,
// division and result hand-off. Depends on wtsp_pkg.
module wtsp_ctrl #(
  parameter int unsigned COORD_WIDTH = wtsp_pkg::CoordWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  wtsp_pkg::status_t status_i,
  output wtsp_pkg::cmd_t    cmd_o
);
  localparam int unsigned ChunkIdxW = wtsp_pkg::ChunkIdxW;
  localparam int unsigned DotChunks = (COORD_WIDTH + wtsp_pkg::ChunkW - 1) / wtsp_pkg::ChunkW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOT,
    S_DRAIN,
    S_CLAMP,
    S_TEST,
    S_SCALE,
    S_DIV,
    S_FINISH
  } state_e;

  state_e               state_q;
  logic [1:0]           row_q, col_q;
  logic [ChunkIdxW-1:0] chunk_q;
  logic                 drain_q;
  logic                 scale_q;
  logic                 zero_q;
  logic                 out_valid_q;
  logic                 accept;
  logic                 dot_last, scale_last;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign dot_last    = (chunk_q == ChunkIdxW'(DotChunks - 1));
  assign scale_last  = (chunk_q == ChunkIdxW'(wtsp_pkg::ScaleChunks - 1));

  // Decode commands from state and counters
  always_comb begin
    cmd_o            = '0;
    cmd_o.a_sel      = wtsp_pkg::A_MAT;
    cmd_o.b_sel      = wtsp_pkg::B_PX;
    cmd_o.dest       = wtsp_pkg::D_ACC_X;
    cmd_o.mat_write  = accept && (in_kind_i == wtsp_pkg::KindLoad);
    cmd_o.point_load = accept && (in_kind_i == wtsp_pkg::KindProject);
    cmd_o.chunk      = chunk_q;
    cmd_o.first      = (chunk_q == '0);
    unique case (state_q)
      S_DOT: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mat_idx = {row_q, col_q};
        cmd_o.b_sel   = wtsp_pkg::b_sel_e'(3'(col_q));
        cmd_o.dest    = wtsp_pkg::dest_e'(3'(row_q));
        cmd_o.last    = dot_last;
      end
      S_SCALE: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.a_sel  = row_q[0] ? wtsp_pkg::A_HEIGHT : wtsp_pkg::A_WIDTH;
        cmd_o.b_sel  = row_q[0] ? wtsp_pkg::B_YC : wtsp_pkg::B_XC;
        cmd_o.dest   = row_q[0] ? wtsp_pkg::D_NUM_Y : wtsp_pkg::D_NUM_X;
        cmd_o.last   = scale_last;
      end
      S_CLAMP: cmd_o.clamp = 1'b1;
      S_FINISH: begin
        cmd_o.res_write = !out_valid_q || out_ready_i;
        cmd_o.res_zero  = zero_q;
      end
      default: ;
    endcase
    // Start the divider once both numerators have settled
    if (state_q == S_DIV && drain_q) cmd_o.div_start = 1'b1;
  end

  // State, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      chunk_q     <= '0;
      drain_q     <= 1'b0;
      scale_q     <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.res_write) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          row_q   <= '0;
          col_q   <= '0;
          chunk_q <= '0;
          scale_q <= 1'b0;
          if (cmd_o.point_load) state_q <= S_DOT;
        end
        S_DOT: begin
          chunk_q <= chunk_q + 1'b1;
          if (dot_last) begin
            chunk_q <= '0;
            col_q   <= col_q + 1'b1;
            if (col_q == 2'd2) begin
              col_q <= '0;
              row_q <= row_q + 1'b1;
              if (row_q == 2'd2) begin
                row_q   <= '0;
                drain_q <= 1'b0;
                state_q <= S_DRAIN;
              end
            end
          end
        end
        S_DRAIN: begin
          drain_q <= 1'b1;
          if (drain_q) state_q <= scale_q ? S_DIV : S_CLAMP;
        end
        S_CLAMP: state_q <= S_TEST;
        S_TEST: begin
          zero_q  <= !status_i.visible;
          state_q <= status_i.visible ? S_SCALE : S_FINISH;
        end
        S_SCALE: begin
          chunk_q <= chunk_q + 1'b1;
          if (scale_last) begin
            chunk_q <= '0;
            row_q   <= row_q + 1'b1;
            if (row_q[0]) begin
              scale_q <= 1'b1;
              drain_q <= 1'b0;
              state_q <= S_DRAIN;
            end
          end
        end
        S_DIV: begin
          // Ignore the done flag left from the previous point in the start cycle
          drain_q <= 1'b0;
          if (status_i.div_done && !drain_q) state_q <= S_FINISH;
        end
        S_FINISH: if (cmd_o.res_write) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Never overwrite a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_write |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

  // A projected point closes the input until its result is written
  a_busy_after_project: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.point_load |=> !in_ready_o)
    else $error("input reopened during projection");

  // Divider start clears the done status
  a_div_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !status_i.div_done)
    else $error("divider done flag stale after start");

  // The multiplier never runs while a result is being written
  a_mul_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_en |-> !cmd_o.res_write && !cmd_o.clamp)
    else $error("multiplier issue overlaps another phase");

endmodule

// ===== src/world_to_screen_projection.sv =====
// Top level of the world-to-screen projector: controller, datapath and channels.
// Depends on wtsp_pkg, wtsp_if, wtsp_ctrl and wtsp_datapath.
//
//   channel  | dir | handshake      | payload
//   in_if    | in  | valid/ready    | kind, entry_index, entry_value, point_x/y/z
//   out_if   | out | valid/ready    | on_screen, screen_x, screen_y
//   cfg      | in  | cfg_we_i only  | cfg_idx_i, cfg_data_i
//
// A projected point runs 9*ceil(COORD_WIDTH/16) dot product digit multiplies on
// the shared 33x17 multiplier, a pipeline drain, clamp and depth test, then 8
// scaling multiplies, another drain and the 63-bit divider before the finish
// state; a point off screen skips from the depth test straight to finish.
// A finished result waits in the output register while the next item is taken;
// the next result stalls in the finish state until the output is free.
// Reset clears control, configuration and the matrix at once; no sweep is needed.
module world_to_screen_projection #(
  parameter int unsigned COORD_WIDTH = wtsp_pkg::CoordWidthDef,
  parameter int unsigned FRAC_BITS   = wtsp_pkg::FracBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wtsp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [wtsp_pkg::CfgDataW-1:0]     cfg_data_i,
  wtsp_in_if.sink                           in_if,
  wtsp_out_if.source                        out_if
);
  wtsp_pkg::cmd_t    cmd;
  wtsp_pkg::status_t status;

  wtsp_ctrl #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_kind_i   (in_if.kind),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  wtsp_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .entry_index_i (in_if.entry_index),
    .entry_value_i (in_if.entry_value),
    .point_x_i     (in_if.point_x),
    .point_y_i     (in_if.point_y),
    .point_z_i     (in_if.point_z),
    .cmd_i         (cmd),
    .status_o      (status),
    .on_screen_o   (out_if.on_screen),
    .screen_x_o    (out_if.screen_x),
    .screen_y_o    (out_if.screen_y)
  );

endmodule
